// ===== rtl/crr_pkg.sv =====
// ----------------------------------------------------------------------------
// crr_pkg: shared types and constants of the camera reply receiver
// Sizes, framing bytes, inquiry codes, status codes and result structs.
// ----------------------------------------------------------------------------
package crr_pkg;

  localparam int MAX_REPLY_BYTES = 14;
  localparam int PENDING_DEPTH   = 8;
  localparam int CNT_W           = $clog2(MAX_REPLY_BYTES + 1);
  localparam int PCNT_W          = $clog2(PENDING_DEPTH + 1);

  // Only reply bytes two through seven are ever read by the field decoder.
  localparam int RB_FIRST = 2;
  localparam int RB_N     = 6;

  typedef logic [RB_N-1:0][7:0] reply_win_t;

  localparam logic [7:0] START_MASK = 8'h90;
  localparam logic [7:0] TERM_BYTE  = 8'hFF;

  localparam logic [1:0] CFG_ACK     = 2'd0;
  localparam logic [1:0] CFG_INQ     = 2'd1;
  localparam logic [1:0] CFG_ERR     = 2'd2;
  localparam logic [1:0] CFG_CMD     = 2'd3;

  localparam logic [2:0] CLS_NONE = 3'd0;
  localparam logic [2:0] CLS_ACK  = 3'd1;
  localparam logic [2:0] CLS_INQ  = 3'd2;
  localparam logic [2:0] CLS_ERR  = 3'd3;
  localparam logic [2:0] CLS_CMD  = 3'd4;

  localparam logic [1:0] PSTAT_NONE  = 2'd0;
  localparam logic [1:0] PSTAT_REPLY = 2'd1;
  localparam logic [1:0] PSTAT_INQ   = 2'd2;

  localparam logic [1:0] DSTAT_IDLE    = 2'd0;
  localparam logic [1:0] DSTAT_EMPTY   = 2'd1;
  localparam logic [1:0] DSTAT_UNKNOWN = 2'd2;
  localparam logic [1:0] DSTAT_DONE    = 2'd3;

  localparam logic [7:0] INQ_ZOOM      = 8'h47;
  localparam logic [7:0] INQ_FOCUS     = 8'h48;
  localparam logic [7:0] INQ_DZOOM_POS = 8'h46;
  localparam logic [7:0] INQ_SHUTTER   = 8'h4A;
  localparam logic [7:0] INQ_IRIS      = 8'h4B;
  localparam logic [7:0] INQ_GAIN      = 8'h4C;
  localparam logic [7:0] INQ_BRIGHT    = 8'h4D;
  localparam logic [7:0] INQ_DZOOM_ON  = 8'h06;
  localparam logic [7:0] INQ_FOCUS_AF  = 8'h38;
  localparam logic [7:0] INQ_DZOOM_MD  = 8'h36;
  localparam logic [7:0] INQ_WB        = 8'h35;
  localparam logic [7:0] INQ_NR        = 8'h53;
  localparam logic [7:0] INQ_AE        = 8'h39;
  localparam logic [7:0] INQ_VERSION   = 8'h02;
  localparam logic [7:0] INQ_LOG_51    = 8'h51;
  localparam logic [7:0] INQ_LOG_01    = 8'h01;
  localparam logic [7:0] INQ_LOG_28    = 8'h28;
  localparam logic [7:0] INQ_LOG_58    = 8'h58;
  localparam logic [7:0] INQ_LOG_57    = 8'h57;
  localparam logic [7:0] INQ_LOG_27    = 8'h27;
  localparam logic [7:0] INQ_LOG_11    = 8'h11;
  localparam logic [7:0] INQ_LOG_3D    = 8'h3D;
  localparam logic [7:0] INQ_LOG_34    = 8'h34;
  localparam logic [7:0] INQ_LOG_37    = 8'h37;
  localparam logic [7:0] INQ_LOG_50    = 8'h50;

  localparam logic [7:0] MODE_ON  = 8'h02;
  localparam logic [7:0] MODE_OFF = 8'h00;
  localparam logic [7:0] NIB_MASK = 8'h0F;

  typedef struct packed {
    logic        known;
    logic [15:0] main_value;
    logic [15:0] extra_value;
  } dec_t;

  typedef struct packed {
    logic [1:0]  packet_status;
    logic [1:0]  decode_status;
    logic [7:0]  inquiry_code;
    logic [15:0] main_value;
    logic [15:0] extra_value;
    logic        queue_dropped;
  } res_t;

endpackage

// ===== rtl/crr_decode.sv =====
// ----------------------------------------------------------------------------
// crr_decode: inquiry field extraction
// Selects the fields of a stored reply that the popped inquiry code names.
// ----------------------------------------------------------------------------
module crr_decode
  import crr_pkg::*;
(
  input  logic [7:0] code,
  input  reply_win_t win,
  output dec_t       dec
);

  logic [7:0] b2, b3, b4, b5, b6, b7;

  assign b2 = win[0];
  assign b3 = win[1];
  assign b4 = win[2];
  assign b5 = win[3];
  assign b6 = win[4];
  assign b7 = win[5];

  always_comb begin
    dec.known       = 1'b1;
    dec.main_value  = '0;
    dec.extra_value = '0;
    case (code)
      INQ_ZOOM, INQ_FOCUS: begin
        dec.main_value = {b2[3:0], b3[3:0], b4[3:0], b5[3:0]};
      end
      INQ_DZOOM_POS, INQ_SHUTTER, INQ_IRIS, INQ_GAIN, INQ_BRIGHT: begin
        dec.main_value = {8'h00, b4[3:0], b5[3:0]};
      end
      INQ_DZOOM_ON, INQ_FOCUS_AF: begin
        dec.main_value = {15'd0, b2 == MODE_ON};
      end
      INQ_DZOOM_MD: begin
        dec.main_value = {15'd0, b2 != MODE_OFF};
      end
      INQ_WB, INQ_NR, INQ_AE: begin
        dec.main_value = {8'h00, b2};
      end
      INQ_VERSION: begin
        dec.main_value  = {b2, b3};
        dec.extra_value = {b6, b7};
      end
      INQ_LOG_51, INQ_LOG_01, INQ_LOG_28, INQ_LOG_58, INQ_LOG_57, INQ_LOG_27,
      INQ_LOG_11, INQ_LOG_3D, INQ_LOG_34, INQ_LOG_37, INQ_LOG_50: begin
        dec.main_value = '0;
      end
      default: begin
        dec.known = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/camera_reply_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// camera_reply_receiver_unit: camera reply framing and inquiry decoding
// Each accepted input beat yields a registered result beat; throughput is
// one beat per cycle unless the input stalls on a full two-entry result
// buffer, which takes the next beat while a stalled consumer holds a result.
// Synchronous active-low reset clears framing, queue count and buffer count.
// ----------------------------------------------------------------------------
module camera_reply_receiver_unit
  import crr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_kind,
  input  logic [7:0]  in_byte_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_packet_status,
  output logic [1:0]  out_decode_status,
  output logic [7:0]  out_inquiry_code,
  output logic [15:0] out_main_value,
  output logic [15:0] out_extra_value,
  output logic        out_queue_dropped,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  logic [7:0] ack_code_r, inq_code_r, err_code_r, cmd_code_r;

  reply_win_t        win_r, win_nxt, win_wr;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              in_pkt_r, in_pkt_nxt;
  logic [2:0]        cls_r, cls_nxt;
  logic [PENDING_DEPTH-1:0][7:0] pq_r, pq_nxt;
  logic [PCNT_W-1:0] pcnt_r, pcnt_nxt;

  res_t       head_r, skid_r, res;
  logic [1:0] ocnt_r;
  logic       push, pop;
  dec_t       dec;

  assign cfg_ready = 1'b1;
  assign in_stall  = (ocnt_r == 2'd2);
  assign out_valid = (ocnt_r != 2'd0);
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  // The decoder sees the reply including the byte of this beat.
  always_comb begin
    win_wr = win_r;
    for (int i = 0; i < RB_N; i++) begin
      if (cnt_r == CNT_W'(i + RB_FIRST)) begin
        win_wr[i] = in_byte_value;
      end
    end
  end

  crr_decode u_decode (
    .code (pq_r[0]),
    .win  (win_wr),
    .dec  (dec)
  );

  always_comb begin
    win_nxt    = win_r;
    cnt_nxt    = cnt_r;
    in_pkt_nxt = in_pkt_r;
    cls_nxt    = cls_r;
    pq_nxt     = pq_r;
    pcnt_nxt   = pcnt_r;
    res        = '0;
    if (in_kind) begin
      if (pcnt_r < PCNT_W'(PENDING_DEPTH)) begin
        for (int i = 0; i < PENDING_DEPTH; i++) begin
          if (pcnt_r == PCNT_W'(i)) begin
            pq_nxt[i] = in_byte_value;
          end
        end
        pcnt_nxt = pcnt_r + 1'b1;
      end else begin
        res.queue_dropped = 1'b1;
      end
    end else if (cnt_r >= CNT_W'(MAX_REPLY_BYTES)) begin
      win_nxt    = '0;
      cnt_nxt    = '0;
      in_pkt_nxt = 1'b0;
      cls_nxt    = CLS_NONE;
    end else begin
      if (in_pkt_r || ((in_byte_value & START_MASK) == START_MASK)) begin
        win_nxt = win_wr;
      end
      if (in_byte_value == TERM_BYTE && in_pkt_r) begin
        cnt_nxt    = '0;
        in_pkt_nxt = 1'b0;
        cls_nxt    = CLS_NONE;
        if (cls_r == CLS_INQ) begin
          res.packet_status = PSTAT_INQ;
          if (pcnt_r == '0) begin
            res.decode_status = DSTAT_EMPTY;
          end else begin
            res.inquiry_code = pq_r[0];
            for (int i = 0; i < PENDING_DEPTH - 1; i++) begin
              pq_nxt[i] = pq_r[i+1];
            end
            pcnt_nxt = pcnt_r - 1'b1;
            if (dec.known) begin
              res.decode_status = DSTAT_DONE;
              res.main_value    = dec.main_value;
              res.extra_value   = dec.extra_value;
            end else begin
              res.decode_status = DSTAT_UNKNOWN;
            end
          end
        end else if (cls_r != CLS_NONE) begin
          res.packet_status = PSTAT_REPLY;
        end
      end else if ((in_byte_value & START_MASK) == START_MASK && !in_pkt_r) begin
        in_pkt_nxt = 1'b1;
        cnt_nxt    = cnt_r + 1'b1;
      end else if (in_pkt_r) begin
        cnt_nxt = cnt_r + 1'b1;
        if (cls_r == CLS_NONE && cnt_r == CNT_W'(1)) begin
          if (in_byte_value == ack_code_r) begin
            cls_nxt = CLS_ACK;
          end else if (in_byte_value == inq_code_r) begin
            cls_nxt = CLS_INQ;
          end else if (in_byte_value == err_code_r) begin
            cls_nxt = CLS_ERR;
          end else if (in_byte_value == cmd_code_r) begin
            cls_nxt = CLS_CMD;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_code_r <= 8'h41;
      inq_code_r <= 8'h50;
      err_code_r <= 8'h60;
      cmd_code_r <= 8'h51;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ACK: ack_code_r <= cfg_wdata;
        CFG_INQ: inq_code_r <= cfg_wdata;
        CFG_ERR: err_code_r <= cfg_wdata;
        CFG_CMD: cmd_code_r <= cfg_wdata;
        default: ack_code_r <= ack_code_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      in_pkt_r <= 1'b0;
      cls_r    <= CLS_NONE;
      pcnt_r   <= '0;
      win_r    <= '0;
    end else if (push) begin
      cnt_r    <= cnt_nxt;
      in_pkt_r <= in_pkt_nxt;
      cls_r    <= cls_nxt;
      pcnt_r   <= pcnt_nxt;
      win_r    <= win_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      pq_r <= pq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= 2'd0;
    end else begin
      ocnt_r <= ocnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push && (ocnt_r == 2'd0 || (ocnt_r == 2'd1 && pop))) begin
      head_r <= res;
    end else if (pop && ocnt_r == 2'd2) begin
      head_r <= skid_r;
    end
    if (push && ocnt_r == 2'd1 && !pop) begin
      skid_r <= res;
    end
  end

  assign out_packet_status = head_r.packet_status;
  assign out_decode_status = head_r.decode_status;
  assign out_inquiry_code  = head_r.inquiry_code;
  assign out_main_value    = head_r.main_value;
  assign out_extra_value   = head_r.extra_value;
  assign out_queue_dropped = head_r.queue_dropped;

endmodule

// ===== rtl/crr_checker.sv =====
// ----------------------------------------------------------------------------
// crr_checker: port-level assertions for the camera reply receiver
// Watches the result channel and its relation to the input stall.
// ----------------------------------------------------------------------------
module crr_checker
  import crr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_packet_status,
  input logic [1:0]  out_decode_status,
  input logic [7:0]  out_inquiry_code,
  input logic [15:0] out_main_value,
  input logic [15:0] out_extra_value,
  input logic        out_queue_dropped
);

  // A result beat held by the consumer stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat withdrawn while stalled");

  // The input side only stalls when results are waiting.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with no result pending");

  a_decode_inq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_decode_status != DSTAT_IDLE |-> out_packet_status == PSTAT_INQ)
    else $error("decode status without inquiry completion");

  a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_packet_status != PSTAT_INQ |->
      out_inquiry_code == 8'h00 && out_main_value == 16'h0000 &&
      out_extra_value == 16'h0000)
    else $error("decoded fields set outside an inquiry completion");

  a_drop_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_queue_dropped |-> out_packet_status == PSTAT_NONE)
    else $error("queue drop reported together with a reply");

endmodule

bind camera_reply_receiver_unit crr_checker u_crr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_packet_status (out_packet_status),
  .out_decode_status (out_decode_status),
  .out_inquiry_code  (out_inquiry_code),
  .out_main_value    (out_main_value),
  .out_extra_value   (out_extra_value),
  .out_queue_dropped (out_queue_dropped)
);
